// ===== hw/rtl/egb_pkg.sv =====
package egb_pkg;

   localparam int STEP_W = 3;

   localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_TEST  = 3'd1;
   localparam logic [STEP_W-1:0] STEP_DINIT = 3'd2;
   localparam logic [STEP_W-1:0] STEP_DSTEP = 3'd3;
   localparam logic [STEP_W-1:0] STEP_UPD   = 3'd4;
   localparam logic [STEP_W-1:0] STEP_DONE  = 3'd5;
   localparam logic [STEP_W-1:0] STEP_WRAP  = 3'd6;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_NO_INPUT,
      COND_DIV_ZERO,
      COND_BITS_LEFT,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      cond_type          cond;
      logic [STEP_W-1:0] target;
      logic              hold;
      logic              take_in;
      logic              div_init;
      logic              div_step;
      logic              update;
      logic              ld_out;
   } ucode_word_type;

   typedef struct packed {
      logic ld_in;
      logic div_init;
      logic div_step;
      logic update;
      logic ld_out;
   } ctl_type;

   typedef struct packed {
      logic div_zero;
      logic bits_left;
   } stat_type;

   function automatic ucode_word_type ucode_rom(logic [STEP_W-1:0] pc);
      ucode_word_type w;
      w = '{cond: COND_NONE, target: STEP_IDLE, default: 1'b0};
      case (pc)
         STEP_IDLE: begin
            w.cond    = COND_NO_INPUT;
            w.target  = STEP_IDLE;
            w.hold    = 1'b1;
            w.take_in = 1'b1;
         end
         STEP_TEST: begin
            w.cond   = COND_DIV_ZERO;
            w.target = STEP_DONE;
         end
         STEP_DINIT: begin
            w.div_init = 1'b1;
         end
         STEP_DSTEP: begin
            w.cond     = COND_BITS_LEFT;
            w.target   = STEP_DSTEP;
            w.div_step = 1'b1;
         end
         STEP_UPD: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_TEST;
            w.update = 1'b1;
         end
         STEP_DONE: begin
            w.cond   = COND_OUT_BUSY;
            w.target = STEP_DONE;
            w.hold   = 1'b1;
            w.ld_out = 1'b1;
         end
         STEP_WRAP: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== hw/rtl/egb_seq.sv =====
module egb_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic              out_busy,
   input  egb_pkg::stat_type stat,
   output logic              in_ready,
   output egb_pkg::ctl_type  ctl
);
   import egb_pkg::*;

   logic [STEP_W-1:0] pc_ff;
   logic [STEP_W-1:0] pc_in;
   ucode_word_type    word;
   logic              hit;
   logic              fire;

   assign word = ucode_rom(pc_ff);

   always_comb begin
      case (word.cond)
         COND_NONE:      hit = 1'b0;
         COND_ALWAYS:    hit = 1'b1;
         COND_NO_INPUT:  hit = ~in_valid;
         COND_DIV_ZERO:  hit = stat.div_zero;
         COND_BITS_LEFT: hit = stat.bits_left;
         COND_OUT_BUSY:  hit = out_busy;
         default:        hit = 1'b1;
      endcase
   end

   // waiting steps only act once their condition clears
   assign fire  = ~(word.hold & hit);
   assign pc_in = hit ? word.target : pc_ff + STEP_W'(1);

   assign in_ready     = word.take_in;
   assign ctl.ld_in    = word.take_in & fire;
   assign ctl.div_init = word.div_init & fire;
   assign ctl.div_step = word.div_step & fire;
   assign ctl.update   = word.update & fire;
   assign ctl.ld_out   = word.ld_out & fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.ld_in |=> pc_ff == STEP_TEST)
      else $error("accepted word did not start the program");

   a_div_runs_after_init: assert property (@(posedge clock) disable iff (reset)
      ctl.div_init |=> ctl.div_step)
      else $error("division did not follow its init step");

   a_out_only_from_done: assert property (@(posedge clock) disable iff (reset)
      ctl.ld_out |-> pc_ff == STEP_DONE && !out_busy)
      else $error("result loaded while output busy");

endmodule

// ===== hw/rtl/egb_dp.sv =====
module egb_dp #(
   parameter int OPERAND_WIDTH = 31
) (
   input  logic                     clock,
   input  logic                     reset,
   input  egb_pkg::ctl_type         ctl,
   input  logic [OPERAND_WIDTH-1:0] first_operand,
   input  logic [OPERAND_WIDTH-1:0] second_operand,
   output egb_pkg::stat_type        stat,
   output logic [OPERAND_WIDTH-1:0] divisor,
   output logic [OPERAND_WIDTH:0]   coeff_a,
   output logic [OPERAND_WIDTH:0]   coeff_b
);
   import egb_pkg::*;

   localparam int W     = OPERAND_WIDTH;
   localparam int C     = OPERAND_WIDTH + 1;
   localparam int CNT_W = $clog2(OPERAND_WIDTH + 1);

   logic [W-1:0]     r0_ff, r1_ff, rem_ff, dvd_ff;
   logic [W-1:0]     r0_in, r1_in, rem_in, dvd_in;
   logic [C-1:0]     s0_ff, s1_ff, t0_ff, t1_ff, accs_ff, acct_ff;
   logic [C-1:0]     s0_in, s1_in, t0_in, t1_in, accs_in, acct_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W:0]       trial;
   logic [W:0]       diff;
   logic             qbit;

   // one quotient bit per cycle, q*s and q*t built msb first alongside
   assign trial = {rem_ff, dvd_ff[W-1]};
   assign diff  = trial - {1'b0, r1_ff};
   assign qbit  = trial >= {1'b0, r1_ff};

   always_comb begin
      r0_in   = r0_ff;
      r1_in   = r1_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      s0_in   = s0_ff;
      s1_in   = s1_ff;
      t0_in   = t0_ff;
      t1_in   = t1_ff;
      accs_in = accs_ff;
      acct_in = acct_ff;
      cnt_in  = cnt_ff;
      if (ctl.ld_in) begin
         r0_in = first_operand;
         r1_in = second_operand;
         s0_in = C'(1);
         s1_in = '0;
         t0_in = '0;
         t1_in = C'(1);
      end
      if (ctl.div_init) begin
         rem_in  = '0;
         dvd_in  = r0_ff;
         accs_in = '0;
         acct_in = '0;
         cnt_in  = CNT_W'(W);
      end
      if (ctl.div_step) begin
         rem_in  = qbit ? diff[W-1:0] : trial[W-1:0];
         dvd_in  = {dvd_ff[W-2:0], 1'b0};
         accs_in = {accs_ff[C-2:0], 1'b0} + (qbit ? s1_ff : '0);
         acct_in = {acct_ff[C-2:0], 1'b0} + (qbit ? t1_ff : '0);
         cnt_in  = cnt_ff - CNT_W'(1);
      end
      if (ctl.update) begin
         r0_in = r1_ff;
         r1_in = rem_ff;
         s0_in = s1_ff;
         s1_in = s0_ff - accs_ff;
         t0_in = t1_ff;
         t1_in = t0_ff - acct_ff;
      end
   end

   always_ff @(posedge clock) begin
      r0_ff   <= r0_in;
      r1_ff   <= r1_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      s0_ff   <= s0_in;
      s1_ff   <= s1_in;
      t0_ff   <= t0_in;
      t1_ff   <= t1_in;
      accs_ff <= accs_in;
      acct_ff <= acct_in;
      cnt_ff  <= cnt_in;
   end

   assign stat.div_zero  = r1_ff == '0;
   assign stat.bits_left = cnt_ff != CNT_W'(1);

   assign divisor = r0_ff;
   assign coeff_a = s0_ff;
   assign coeff_b = t0_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      ctl.div_step |-> rem_ff < r1_ff)
      else $error("partial remainder reached the divisor");

   a_remainder_shrinks: assert property (@(posedge clock) disable iff (reset)
      ctl.update |=> r1_ff < $past(r1_ff))
      else $error("remainder did not shrink");

   a_step_count_live: assert property (@(posedge clock) disable iff (reset)
      ctl.div_step |-> cnt_ff != '0)
      else $error("division ran past its last bit");

endmodule

// ===== hw/rtl/extended_gcd_bezout_top.sv =====
// Extended Euclid: for operands a and b on req_tdata the block returns g = gcd(a, b) and
// coefficients x, y with a*x + b*y = g, x and y being those of the recursive scheme (b = 0
// gives g = a, x = 1, y = 0). A small microcode program in a table steps a datapath
// with a restoring divider that retires one quotient bit per cycle while q*x and q*y are
// accumulated beside it. Each quotient step runs the steps TEST, DINIT, one DSTEP per
// quotient bit and UPD; for 31-bit operands there are at most 45 quotient steps. One word
// is worked on at a time; the result sits in an output register so the next word can be
// taken while it waits.
module extended_gcd_bezout_top #(
   parameter int OPERAND_WIDTH = 31
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // first_operand, second_operand
   input  logic [((2 * OPERAND_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // divisor, coeff_a, coeff_b
   output logic [((3 * OPERAND_WIDTH + 2 + 7) / 8) * 8 - 1:0] rsp_tdata
);
   import egb_pkg::*;

   localparam int W     = OPERAND_WIDTH;
   localparam int RSP_W = ((3 * OPERAND_WIDTH + 2 + 7) / 8) * 8;
   localparam int FLD_W = 3 * OPERAND_WIDTH + 2;

   ctl_type        ctl;
   stat_type       stat;
   logic [W-1:0]   divisor;
   logic [W:0]     coeff_a, coeff_b;
   logic           rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic           out_busy;

   assign out_busy = rsp_tvalid_ff & ~rsp_tready;

   egb_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .out_busy (out_busy),
      .stat     (stat),
      .in_ready (req_tready),
      .ctl      (ctl)
   );

   egb_dp #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .first_operand  (req_tdata[W-1:0]),
      .second_operand (req_tdata[2*W-1:W]),
      .stat           (stat),
      .divisor        (divisor),
      .coeff_a        (coeff_a),
      .coeff_b        (coeff_b)
   );

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      if (ctl.ld_out) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = RSP_W'({coeff_b, coeff_a, divisor});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.ld_out |-> !rsp_tvalid_ff || rsp_tready)
      else $error("pending result overwritten");

   a_one_word_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word taken while one is in progress");

   a_result_follows_load: assert property (@(posedge clock) disable iff (reset)
      ctl.ld_out |=> rsp_tvalid && rsp_tdata[FLD_W-1:0] == $past({coeff_b, coeff_a, divisor}))
      else $error("result word does not match datapath");

endmodule
